/* rtl/vtpd_pkg.sv */
package vtpd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	localparam int REG_COUNT = 8;
	localparam int REG_W     = 64;
	localparam int IDX_W     = $clog2(REG_COUNT);

	localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [REG_W-1:0] reg_t;

	typedef enum logic [1:0] {
		CMD_POINT2  = 2'd0,
		CMD_POINT3  = 2'd1,
		CMD_VECTOR4 = 2'd2,
		CMD_PROJECT = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t  cmd;
		word_t t0;
		word_t t1;
		word_t t2;
		word_t t3;
	} side_t;

	function automatic reg_t reg_reset(input int i);
		reg_t r;
		r = '0;
		if (i == 0 || i == 5) r = {{DATA_W{1'b0}}, ONE};
		if (i == 2 || i == 7) r = {ONE, {DATA_W{1'b0}}};
		return r;
	endfunction

endpackage

/* rtl/vertex_transform_perspective_divide.sv */
// Vertex transform: row vector times a 4x4 Q16.16 matrix, then perspective divide except in vector4 mode.
// Input word: s_tuser = command, s_tdata = x, y, z, w (32 bits each, x lowest).
// Output word: m_tdata = x, y, z, w results, m_tuser = divide_by_zero.
// Matrix registers are written on the cfg channel (index 0..7, 64-bit data),
// always ready; write only while no vertex is in flight.
// Four column lanes each run four 32x32 multipliers (one stage) and a
// saturating sum (one stage). Three lanes of a bit-per-stage restoring divider
// (48 stages) follow, then an output register.
// Throughput is one vertex per cycle; every stage is a pipeline register.
// The whole pipeline advances when the output register is empty or being
// taken; s_tready follows that, so a stalled receiver holds everything and
// no word is dropped. Bubbles are not squeezed out: a stalled output stops input.
// Reset clears all valid bits and loads the identity matrix.
module vertex_transform_perspective_divide (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [127:0]                s_tdata,  // in_x, in_y, in_z, in_w
	input  logic [1:0]                  s_tuser,  // command
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [127:0]                m_tdata,  // out_x, out_y, out_z, out_w
	output logic [0:0]                  m_tuser,  // divide_by_zero
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vtpd_pkg::IDX_W-1:0]  cfg_index,
	input  logic [vtpd_pkg::REG_W-1:0]  cfg_data
);

	localparam int N = vtpd_pkg::NUM_W;
	localparam int D = vtpd_pkg::DATA_W;

	vtpd_pkg::reg_t   m_q [vtpd_pkg::REG_COUNT];
	logic             en;
	vtpd_pkg::cmd_t   cmd_in;
	vtpd_pkg::word_t  v [4];
	vtpd_pkg::word_t  t [4];
	vtpd_pkg::word_t  q [3];
	vtpd_pkg::cmd_t   cmd_s1, cmd_s2;
	logic             v_s1, v_s2;
	logic             vd_s [N];
	vtpd_pkg::side_t  sd_s [N];
	vtpd_pkg::side_t  side_in, side_o;
	logic             zero;
	vtpd_pkg::word_t  o [4];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vtpd_pkg::REG_COUNT; i++) m_q[i] <= vtpd_pkg::reg_reset(i);
		end else if (cfg_valid && cfg_ready) begin
			m_q[cfg_index] <= cfg_data;
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign cmd_in = vtpd_pkg::cmd_t'(s_tuser);
	assign v[0] = s_tdata[31:0];
	assign v[1] = s_tdata[63:32];
	assign v[2] = (cmd_in == vtpd_pkg::CMD_POINT2) ? '0 : s_tdata[95:64];
	assign v[3] = (cmd_in == vtpd_pkg::CMD_VECTOR4) ? s_tdata[127:96] : vtpd_pkg::ONE;

	for (genvar c = 0; c < 4; c++) begin : g_lane
		vtpd_pkg::word_t mc [4];
		for (genvar r = 0; r < 4; r++) begin : g_col
			assign mc[r] = m_q[r*2 + c/2][(c%2)*D +: D];
		end
		vtpd_lane u_lane (
			.clk    (clk),
			.en     (en),
			.v      (v),
			.m      (mc),
			.t      (t[c])
		);
	end

	for (genvar c = 0; c < 3; c++) begin : g_div
		vtpd_div u_div (
			.clk    (clk),
			.en     (en),
			.a      (t[c]),
			.w      (t[3]),
			.q      (q[c])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_in;
			cmd_s2 <= cmd_s1;
		end
	end

	assign side_in = '{cmd: cmd_s2, t0: t[0], t1: t[1], t2: t[2], t3: t[3]};

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_in;
			for (int k = 1; k < N; k++) sd_s[k] <= sd_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < N; k++) vd_s[k] <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			vd_s[0] <= v_s2;
			for (int k = 1; k < N; k++) vd_s[k] <= vd_s[k-1];
			m_tvalid <= vd_s[N-1];
		end
	end

	assign side_o = sd_s[N-1];
	assign zero   = side_o.t3 == '0;

	always_comb begin
		o[0] = '0;
		o[1] = '0;
		o[2] = '0;
		o[3] = '0;
		unique case (side_o.cmd)
			vtpd_pkg::CMD_VECTOR4: begin
				o[0] = side_o.t0;
				o[1] = side_o.t1;
				o[2] = side_o.t2;
				o[3] = side_o.t3;
			end
			vtpd_pkg::CMD_POINT3: begin
				o[0] = zero ? '0 : q[0];
				o[1] = zero ? '0 : q[1];
				o[2] = zero ? '0 : q[2];
			end
			vtpd_pkg::CMD_PROJECT: begin
				o[0] = zero ? '0 : q[0];
				o[1] = zero ? '0 : q[1];
				o[2] = side_o.t2;
			end
			default: begin
				o[0] = zero ? '0 : q[0];
				o[1] = zero ? '0 : q[1];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata    <= {o[3], o[2], o[1], o[0]};
			m_tuser[0] <= zero && (side_o.cmd != vtpd_pkg::CMD_VECTOR4);
		end
	end

`ifndef SYNTHESIS
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");
	a_zero_xy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == '0))
		else $error("divided outputs not zero on zero w");
	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[127:96] == '0))
		else $error("w output set in a dividing mode");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output word changed while stalled");
`endif

endmodule

/* rtl/vtpd_lane.sv */
module vtpd_lane (
	input  logic                clk,
	input  logic                en,
	input  vtpd_pkg::word_t     v [4],
	input  vtpd_pkg::word_t     m [4],
	output vtpd_pkg::word_t     t
);

	logic signed [vtpd_pkg::PROD_W-1:0] prod_s1 [4];
	logic signed [vtpd_pkg::SUM_W-1:0]  sum;
	vtpd_pkg::word_t                    t_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) prod_s1[r] <= v[r] * m[r];
		end
	end

	always_comb begin
		sum = '0;
		for (int r = 0; r < 4; r++)
			sum = sum + vtpd_pkg::SUM_W'(prod_s1[r] >>> vtpd_pkg::FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sum > vtpd_pkg::SUM_W'(signed'(vtpd_pkg::SAT_MAX)))
				t_s2 <= vtpd_pkg::SAT_MAX;
			else if (sum < vtpd_pkg::SUM_W'(signed'(vtpd_pkg::SAT_MIN)))
				t_s2 <= vtpd_pkg::SAT_MIN;
			else
				t_s2 <= sum[vtpd_pkg::DATA_W-1:0];
		end
	end

	assign t = t_s2;

endmodule

/* rtl/vtpd_div.sv */
module vtpd_div (
	input  logic            clk,
	input  logic            en,
	input  vtpd_pkg::word_t a,
	input  vtpd_pkg::word_t w,
	output vtpd_pkg::word_t q
);

	localparam int N = vtpd_pkg::NUM_W;
	localparam int D = vtpd_pkg::DATA_W;

	logic [D-1:0] rem_s [N];
	logic [N-1:0] qn_s  [N];
	logic [D-1:0] d_s   [N];
	logic         neg_s [N];

	logic [D-1:0] a_mag, w_mag;
	logic [N-1:0] res;

	assign a_mag = a[D-1] ? D'(-a) : D'(a);
	assign w_mag = w[D-1] ? D'(-w) : D'(w);

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D-1:0] rp, dp;
		logic [N-1:0] qp;
		logic         np;
		logic [D:0]   tr;
		logic         ge;
		if (k == 0) begin : g_first
			assign rp = '0;
			assign qp = {a_mag, {vtpd_pkg::FRAC_BITS{1'b0}}};
			assign dp = w_mag;
			assign np = a[D-1] ^ w[D-1];
		end else begin : g_next
			assign rp = rem_s[k-1];
			assign qp = qn_s[k-1];
			assign dp = d_s[k-1];
			assign np = neg_s[k-1];
		end
		assign tr = {rp, qp[N-1]};
		assign ge = tr >= {1'b0, dp};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? D'(tr - {1'b0, dp}) : tr[D-1:0];
				qn_s[k]  <= {qp[N-2:0], ge};
				d_s[k]   <= dp;
				neg_s[k] <= np;
			end
		end
	end

	assign res = qn_s[N-1];

	always_comb begin
		if (!neg_s[N-1]) begin
			q = (res > N'(vtpd_pkg::SAT_MAX)) ? vtpd_pkg::SAT_MAX : res[D-1:0];
		end else begin
			q = (res > N'(vtpd_pkg::SAT_MIN)) ? vtpd_pkg::SAT_MIN : D'(-res[D-1:0]);
		end
	end

endmodule

/* dv/vertex_transform_perspective_divide_checker.sv */
module vertex_transform_perspective_divide_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [127:0]                  s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [127:0]                  m_tdata,
	input  logic [0:0]                    m_tuser,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [vtpd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [vtpd_pkg::REG_W-1:0]    cfg_data,
	output int                            errors,
	output int                            pending
);

	typedef struct packed {
		logic [127:0] xyzw;
		logic         dz;
	} vertex_out_t;

	vtpd_pkg::reg_t matrix [vtpd_pkg::REG_COUNT];
	vertex_out_t    vertex_q [$];

	function automatic longint sat_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint coef(input int r, input int c);
		vtpd_pkg::reg_t  rv;
		vtpd_pkg::word_t e;
		rv = matrix[r * 2 + c / 2];
		e = (c % 2) ? rv[63:32] : rv[31:0];
		return longint'(e);
	endfunction

	function automatic longint quot(input longint a, input longint w);
		longint num;
		num = a * (64'sd1 <<< vtpd_pkg::FRAC_BITS);
		return sat_word(num / w);
	endfunction

	function automatic vertex_out_t transform(input vtpd_pkg::cmd_t cmd,
		input logic [127:0] d);
		longint      v [4];
		longint      t [4];
		longint      o [4];
		longint      acc;
		vertex_out_t res;
		v[0] = longint'(vtpd_pkg::word_t'(d[31:0]));
		v[1] = longint'(vtpd_pkg::word_t'(d[63:32]));
		v[2] = (cmd == vtpd_pkg::CMD_POINT2) ? 0 : longint'(vtpd_pkg::word_t'(d[95:64]));
		v[3] = (cmd == vtpd_pkg::CMD_VECTOR4) ? longint'(vtpd_pkg::word_t'(d[127:96])) :
			(64'sd1 <<< vtpd_pkg::FRAC_BITS);
		for (int c = 0; c < 4; c++) begin
			acc = 0;
			for (int r = 0; r < 4; r++)
				acc += (v[r] * coef(r, c)) >>> vtpd_pkg::FRAC_BITS;
			t[c] = sat_word(acc);
			o[c] = 0;
		end
		res.dz = 1'b0;
		if (cmd == vtpd_pkg::CMD_VECTOR4) begin
			for (int c = 0; c < 4; c++) o[c] = t[c];
		end else begin
			if (t[3] == 0) begin
				res.dz = 1'b1;
			end else begin
				o[0] = quot(t[0], t[3]);
				o[1] = quot(t[1], t[3]);
				if (cmd == vtpd_pkg::CMD_POINT3) o[2] = quot(t[2], t[3]);
			end
			if (cmd == vtpd_pkg::CMD_PROJECT) o[2] = t[2];
		end
		res.xyzw = {o[3][31:0], o[2][31:0], o[1][31:0], o[0][31:0]};
		return res;
	endfunction

	assign pending = vertex_q.size();

	always @(posedge clk or negedge arst_n) begin
		vertex_out_t exp_v;
		if (!arst_n) begin
			for (int i = 0; i < vtpd_pkg::REG_COUNT; i++) matrix[i] = vtpd_pkg::reg_reset(i);
			vertex_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) matrix[cfg_index] = cfg_data;
			if (s_tvalid && s_tready)
				vertex_q.push_back(transform(vtpd_pkg::cmd_t'(s_tuser), s_tdata));
			if (m_tvalid && m_tready) begin
				if (vertex_q.size() == 0) begin
					$error("unexpected word %h", m_tdata);
					errors++;
				end else begin
					exp_v = vertex_q.pop_front();
					for (int f = 0; f < 4; f++)
						if (m_tdata[f*32 +: 32] !== exp_v.xyzw[f*32 +: 32]) begin
							$error("out_%s expected %h actual %h", f == 0 ? "x" : f == 1 ? "y" :
								f == 2 ? "z" : "w", exp_v.xyzw[f*32 +: 32], m_tdata[f*32 +: 32]);
							errors++;
						end
					if (m_tuser[0] !== exp_v.dz) begin
						$error("divide_by_zero expected %b actual %b", exp_v.dz, m_tuser[0]);
						errors++;
					end
				end
			end
		end
	end

endmodule

/* dv/vertex_transform_perspective_divide_test.sv */
module vertex_transform_perspective_divide_test;

	localparam int LATENCY = 51;
	localparam int IDLE_LIMIT = 20000;

	logic                        clk = 0;
	logic                        arst_n = 0;
	logic                        s_tvalid = 0;
	logic                        s_tready;
	logic [127:0]                s_tdata = '0;
	logic [1:0]                  s_tuser = '0;
	logic                        m_tvalid;
	logic                        m_tready = 0;
	logic [127:0]                m_tdata;
	logic [0:0]                  m_tuser;
	logic                        cfg_valid = 0;
	logic                        cfg_ready;
	logic [vtpd_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [vtpd_pkg::REG_W-1:0]  cfg_data = '0;
	int                          errors;
	int                          pending;
	int                          idle_cycles = 0;
	bit                          hold_sink = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	vertex_transform_perspective_divide i_dut (.*);

	vertex_transform_perspective_divide_checker i_chk (.*);

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'h00010000;
			4: return 32'hffff0000;
			5: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [63:0] rand_entry_pair();
		logic [63:0] v;
		for (int h = 0; h < 2; h++)
			v[h*32 +: 32] = ($urandom_range(0, 3) == 0) ? rand_word() :
				32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
		return v;
	endfunction

	task automatic send_vertex(input vtpd_pkg::cmd_t cmd, input logic [127:0] d);
		int g;
		cfg_valid <= 0;
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_matrix(input int idx, input vtpd_pkg::reg_t v);
		cfg_valid <= 1;
		cfg_index <= vtpd_pkg::IDX_W'(idx);
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (hold_sink) m_tready <= 0;
		else m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 9) == 0 ? 1'b0 : 1'b0);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("vertex_transform_perspective_divide: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity matrix, directed extremes
		for (int c = 0; c < 4; c++) begin
			send_vertex(vtpd_pkg::cmd_t'(c),
				{32'h00010000, 32'h00030000, 32'hfffe0000, 32'h00050000});
			send_vertex(vtpd_pkg::cmd_t'(c), {4{32'h7fffffff}});
			send_vertex(vtpd_pkg::cmd_t'(c), {4{32'h80000000}});
			send_vertex(vtpd_pkg::cmd_t'(c), {32'h0, 32'h0, 32'h80000000, 32'h7fffffff});
		end
		send_vertex(vtpd_pkg::CMD_VECTOR4, {32'h0, 32'h12345678, 32'hdeadbeef, 32'h0});
		drain();

		// zero w' for dividing modes
		for (int i = 0; i < vtpd_pkg::REG_COUNT; i++)
			write_matrix(i, (i == 7) ? 64'h0 : vtpd_pkg::reg_reset(i));
		for (int c = 0; c < 4; c++) send_vertex(vtpd_pkg::cmd_t'(c), {4{32'h00020000}});
		drain();

		// all-ones matrix, then a matrix of largest and most negative entries
		for (int i = 0; i < vtpd_pkg::REG_COUNT; i++) write_matrix(i, '1);
		for (int c = 0; c < 4; c++)
			send_vertex(vtpd_pkg::cmd_t'(c), {$urandom(), $urandom(), $urandom(), $urandom()});
		drain();
		for (int i = 0; i < vtpd_pkg::REG_COUNT; i++) write_matrix(i, 64'h7fffffff_80000000);
		for (int c = 0; c < 4; c++) send_vertex(vtpd_pkg::cmd_t'(c), {4{32'h7fffffff}});
		drain();

		// random phases: identity matrix first, then random matrices
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < vtpd_pkg::REG_COUNT; i++)
				write_matrix(i, (ph == 0) ? vtpd_pkg::reg_reset(i) : rand_entry_pair());
			if (ph == 2) begin
				fork
					begin
						hold_sink = 1;
						repeat (300) @(posedge clk);
						hold_sink = 0;
					end
				join_none
			end
			for (int n = 0; n < 90; n++) begin
				send_vertex(vtpd_pkg::cmd_t'($urandom_range(0, 3)),
					{rand_word(), rand_word(), rand_word(), rand_word()});
				if (ph == 3 && n == 45) drain();
			end
			drain();
		end

		if (errors == 0)
			$display("vertex_transform_perspective_divide: match");
		else
			$display("vertex_transform_perspective_divide: mismatch");
		$finish;
	end

endmodule

/* sim.f */
rtl/vtpd_pkg.sv
rtl/vtpd_lane.sv
rtl/vtpd_div.sv
rtl/vertex_transform_perspective_divide.sv
dv/vertex_transform_perspective_divide_checker.sv
dv/vertex_transform_perspective_divide_test.sv
